// ===== rtl/core/prwa_pkg.sv =====
// peer registry with aging: shared types, codes and sizes
// no dependencies; imported by peer_registry_with_aging, prwa_engine and the testbench
package prwa_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int OPCODE_W = 2;
   localparam int IP_W = 32;
   localparam int PORT_W = 16;
   localparam int TIME_W = 32;
   localparam int TIMEOUT_W = 16;
   localparam int STATUS_W = 3;
   localparam int SLOT_W = 6;
   localparam int COUNT_W = 6;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

   localparam logic [OPCODE_W-1:0] OP_REGISTER = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SWEEP = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LIST = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_REFRESHED = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_ADDED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_LISTED = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_END = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_SWEPT = 3'd5;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      logic [TIME_W-1:0] seen;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [IP_W-1:0]     ip;
      logic [PORT_W-1:0]   port;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } rsp_item_type;

endpackage

// ===== rtl/core/peer_registry_with_aging.sv =====
// peer registry with aging: top level, timeout register and result register
// depends on prwa_pkg and prwa_engine
//
//  channel   ports                        handshake
//  request   req_opcode .. current_time   req_valid / req_ready
//  result    rsp_status .. rsp_last       rsp_valid / rsp_ready
//  config    csr_wr_data (timeout)        csr_wr_en, no wait
//
// items scan the slots through the one ram read port, one slot a cycle but for stalls;
// a register item that matches a slot stops its scan there, and an unused opcode is
// taken without a scan and gives no result
// a list item stalls on the slot being listed while the result register is full
// the next item is taken once the final result sits in the result register
// synchronous active-high reset clears the slot valid flags; no clearing pass
module peer_registry_with_aging
   import prwa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [IP_W-1:0]      req_peer_ip,
   input  logic [PORT_W-1:0]    req_peer_port,
   input  logic [TIME_W-1:0]    req_current_time,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [IP_W-1:0]      rsp_entry_ip,
   output logic [PORT_W-1:0]    rsp_entry_port,
   output logic [COUNT_W-1:0]   rsp_expired_count,
   output logic                 rsp_last,
   input  logic                 csr_wr_en,
   input  logic [TIMEOUT_W-1:0] csr_wr_data
);

   logic [TIMEOUT_W-1:0] timeout_ff;
   logic rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   logic out_free, push;
   rsp_item_type push_item;

   assign out_free = !rsp_valid_ff || rsp_ready;

   prwa_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_peer_ip     (req_peer_ip),
      .req_peer_port   (req_peer_port),
      .req_current_time(req_current_time),
      .timeout         (timeout_ff),
      .out_free        (out_free),
      .push            (push),
      .push_item       (push_item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_item_ff <= push_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_item_ff.status;
   assign rsp_slot = rsp_item_ff.slot;
   assign rsp_entry_ip = rsp_item_ff.ip;
   assign rsp_entry_port = rsp_item_ff.port;
   assign rsp_expired_count = rsp_item_ff.count;
   assign rsp_last = rsp_item_ff.last;

endmodule

// ===== rtl/core/prwa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module prwa_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/prwa_engine.sv =====
// scan engine: slot valid flags, entry ram and the per-item sequencer
// depends on prwa_pkg and prwa_ram
module prwa_engine
   import prwa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [IP_W-1:0]      req_peer_ip,
   input  logic [PORT_W-1:0]    req_peer_port,
   input  logic [TIME_W-1:0]    req_current_time,
   input  logic [TIMEOUT_W-1:0] timeout,
   input  logic                 out_free,
   output logic                 push,
   output rsp_item_type         push_item
);

   state_type state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [IP_W-1:0] ip_ff, ip_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0] eval_idx_ff, eval_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic ram_we, ram_re;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   entry_type ram_wdata, ram_rdata;

   logic cur_valid, cur_match, cur_expired, hold, stop;
   logic [TIME_W-1:0] age;

   prwa_ram #(
      .DATA_W($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES),
      .ADDR_W(IDX_W)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         eval_vld_ff <= 1'b0;
         hit_ff <= 1'b0;
         free_ff <= 1'b0;
         count_ff <= '0;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         eval_vld_ff <= eval_vld_in;
         hit_ff <= hit_in;
         free_ff <= free_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      ip_ff <= ip_in;
      port_ff <= port_in;
      now_ff <= now_in;
      eval_idx_ff <= eval_idx_in;
      hit_idx_ff <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   assign cur_valid = valid_ff[eval_idx_ff];
   assign cur_match = (ram_rdata.ip == ip_ff) && (ram_rdata.port == port_ff);
   assign age = now_ff - ram_rdata.seen;
   assign cur_expired = age >= {{(TIME_W-TIMEOUT_W){1'b0}}, timeout};
   assign hold = eval_vld_ff && (op_ff == OP_LIST) && cur_valid && !out_free;
   assign stop = eval_vld_ff && (op_ff == OP_REGISTER) && cur_valid && cur_match;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      ip_in = ip_ff;
      port_in = port_ff;
      now_in = now_ff;
      issue_in = issue_ff;
      eval_vld_in = eval_vld_ff;
      eval_idx_in = eval_idx_ff;
      valid_in = valid_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      count_in = count_ff;
      req_ready = 1'b0;
      ram_we = 1'b0;
      ram_waddr = hit_idx_ff;
      ram_wdata = '{ip: ip_ff, port: port_ff, seen: now_ff};
      ram_re = 1'b0;
      ram_raddr = issue_ff[IDX_W-1:0];
      push = 1'b0;
      push_item = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = req_opcode;
               ip_in = req_peer_ip;
               port_in = req_peer_port;
               now_in = req_current_time;
               issue_in = '0;
               eval_vld_in = 1'b0;
               hit_in = 1'b0;
               free_in = 1'b0;
               count_in = '0;
               if (req_opcode != OP_UNUSED) begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (!hold) begin
               // evaluate the slot whose data just came out of the ram
               if (eval_vld_ff) begin
                  unique case (op_ff)
                     OP_REGISTER: begin
                        if (stop) begin
                           hit_in = 1'b1;
                           hit_idx_in = eval_idx_ff;
                        end else if (!cur_valid && !free_ff) begin
                           free_in = 1'b1;
                           free_idx_in = eval_idx_ff;
                        end
                     end
                     OP_SWEEP: begin
                        if (cur_valid && cur_expired) begin
                           valid_in[eval_idx_ff] = 1'b0;
                           count_in = count_ff + 1'b1;
                        end
                     end
                     OP_LIST: begin
                        if (cur_valid) begin
                           push = 1'b1;
                           push_item.status = STAT_LISTED;
                           push_item.slot = SLOT_W'(eval_idx_ff);
                           push_item.ip = ram_rdata.ip;
                           push_item.port = ram_rdata.port;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               // issue the next read
               if (!stop && (issue_ff < CNT_W'(TABLE_ENTRIES))) begin
                  ram_re = 1'b1;
                  eval_vld_in = 1'b1;
                  eval_idx_in = issue_ff[IDX_W-1:0];
                  issue_in = issue_ff + 1'b1;
               end else begin
                  eval_vld_in = 1'b0;
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            if (out_free) begin
               push = 1'b1;
               push_item.last = 1'b1;
               state_in = S_IDLE;
               unique case (op_ff)
                  OP_REGISTER: begin
                     if (hit_ff) begin
                        ram_we = 1'b1;
                        ram_waddr = hit_idx_ff;
                        push_item.status = STAT_REFRESHED;
                        push_item.slot = SLOT_W'(hit_idx_ff);
                        push_item.ip = ip_ff;
                        push_item.port = port_ff;
                     end else if (free_ff) begin
                        ram_we = 1'b1;
                        ram_waddr = free_idx_ff;
                        valid_in[free_idx_ff] = 1'b1;
                        push_item.status = STAT_ADDED;
                        push_item.slot = SLOT_W'(free_idx_ff);
                        push_item.ip = ip_ff;
                        push_item.port = port_ff;
                     end else begin
                        push_item.status = STAT_FULL;
                     end
                  end
                  OP_SWEEP: begin
                     push_item.status = STAT_SWEPT;
                     push_item.count = count_ff;
                  end
                  default: begin
                     push_item.status = STAT_END;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result pushed while output register is occupied");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("entry ram read and written in the same cycle");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (state_ff == S_IDLE))
      else $error("final item not delivered on time");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TABLE_ENTRIES))
      else $error("expired count exceeds table size");

   a_hit_only_register: assert property (@(posedge clock) disable iff (reset)
      (hit_ff && state_ff != S_IDLE) |-> (op_ff == OP_REGISTER))
      else $error("match flag set outside a register item");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for peer_registry_with_aging: a directed table, then random phases
// checked against an in-bench model of the peer table; needs prwa_pkg and the rtl
module tb_top;
   import prwa_pkg::*;

   localparam int PHASE_ITEMS = 80;
   localparam int NUM_PHASES = 5;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT = 100000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 40;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [IP_W-1:0]     ip;
      logic [PORT_W-1:0]   port;
      logic [TIME_W-1:0]   now;
      bit                  typed;
      rsp_item_type        want;
   } peer_req_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [OPCODE_W-1:0]  req_opcode;
   logic [IP_W-1:0]      req_peer_ip;
   logic [PORT_W-1:0]    req_peer_port;
   logic [TIME_W-1:0]    req_current_time;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [IP_W-1:0]      rsp_entry_ip;
   logic [PORT_W-1:0]    rsp_entry_port;
   logic [COUNT_W-1:0]   rsp_expired_count;
   logic                 rsp_last;
   logic                 csr_wr_en;
   logic [TIMEOUT_W-1:0] csr_wr_data;

   // model of the peer table
   bit                   registry_valid [TABLE_ENTRIES];
   logic [IP_W-1:0]      registry_ip [TABLE_ENTRIES];
   logic [PORT_W-1:0]    registry_port [TABLE_ENTRIES];
   logic [TIME_W-1:0]    registry_seen [TABLE_ENTRIES];
   logic [TIMEOUT_W-1:0] timeout_model;

   rsp_item_type         expected_rsps[$];
   peer_req_type         directed_rows[$];
   logic [47:0]          known_peers[$];
   logic [TIME_W-1:0]    now_s = '0;
   int                   mismatch_count = 0;
   bit                   idle_on = 1'b1;
   bit                   stall_on = 1'b1;
   bit                   long_hold = 1'b0;

   peer_registry_with_aging dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_peer_ip       (req_peer_ip),
      .req_peer_port     (req_peer_port),
      .req_current_time  (req_current_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_entry_ip      (rsp_entry_ip),
      .rsp_entry_port    (rsp_entry_port),
      .rsp_expired_count (rsp_expired_count),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("peer_registry_with_aging: mismatch");
      $finish;
   end

   function automatic rsp_item_type mk_rsp(input logic [STATUS_W-1:0] st, input int slot_num,
                                           input logic [IP_W-1:0] ip,
                                           input logic [PORT_W-1:0] port,
                                           input int cnt, input bit fin);
      rsp_item_type r;
      r.status = st;
      r.slot = SLOT_W'(slot_num);
      r.ip = ip;
      r.port = port;
      r.count = COUNT_W'(cnt);
      r.last = fin;
      return r;
   endfunction

   function automatic void add_row(input logic [OPCODE_W-1:0] op, input logic [IP_W-1:0] ip,
                                   input logic [PORT_W-1:0] port,
                                   input logic [TIME_W-1:0] now, input bit typed,
                                   input rsp_item_type want);
      peer_req_type r;
      r.opcode = op;
      r.ip = ip;
      r.port = port;
      r.now = now;
      r.typed = typed;
      r.want = want;
      directed_rows.push_back(r);
   endfunction

   // updates the table model and queues the results one item causes
   function automatic void predict_results(input peer_req_type r);
      int hit;
      int free_slot;
      int freed;
      int i;
      logic [TIME_W-1:0] age;
      rsp_item_type outs[$];
      hit = -1;
      free_slot = -1;
      freed = 0;
      case (r.opcode)
         OP_REGISTER: begin
            for (i = 0; i < TABLE_ENTRIES; i++) begin
               if (registry_valid[i]) begin
                  if (hit < 0 && registry_ip[i] == r.ip && registry_port[i] == r.port)
                     hit = i;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (hit >= 0) begin
               registry_seen[hit] = r.now;
               outs.push_back(mk_rsp(STAT_REFRESHED, hit, r.ip, r.port, 0, 1'b1));
            end else if (free_slot < 0) begin
               outs.push_back(mk_rsp(STAT_FULL, 0, '0, '0, 0, 1'b1));
            end else begin
               registry_valid[free_slot] = 1'b1;
               registry_ip[free_slot] = r.ip;
               registry_port[free_slot] = r.port;
               registry_seen[free_slot] = r.now;
               outs.push_back(mk_rsp(STAT_ADDED, free_slot, r.ip, r.port, 0, 1'b1));
            end
         end
         OP_SWEEP: begin
            for (i = 0; i < TABLE_ENTRIES; i++) begin
               age = r.now - registry_seen[i];
               if (registry_valid[i] && age >= TIME_W'(timeout_model)) begin
                  registry_valid[i] = 1'b0;
                  freed++;
               end
            end
            outs.push_back(mk_rsp(STAT_SWEPT, 0, '0, '0, freed, 1'b1));
         end
         OP_LIST: begin
            for (i = 0; i < TABLE_ENTRIES; i++) begin
               if (registry_valid[i])
                  outs.push_back(mk_rsp(STAT_LISTED, i, registry_ip[i], registry_port[i],
                                        0, 1'b0));
            end
            outs.push_back(mk_rsp(STAT_END, 0, '0, '0, 0, 1'b1));
         end
         default: ;
      endcase
      if (r.typed && outs.size() == 1)
         outs[0] = r.want;
      foreach (outs[k])
         expected_rsps.push_back(outs[k]);
   endfunction

   function automatic peer_req_type random_request();
      peer_req_type r;
      int pick;
      logic [47:0] peer;
      r.typed = 1'b0;
      r.want = '0;
      r.ip = $urandom;
      r.port = PORT_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 80)
         now_s += $urandom_range(0, 8);
      else if (pick < 95)
         now_s += $urandom_range(0, 2 * int'(timeout_model) + 2);
      else
         now_s = $urandom;
      r.now = now_s;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         r.opcode = OP_REGISTER;
         if (known_peers.size() != 0 && $urandom_range(0, 1) == 1) begin
            peer = known_peers[$urandom_range(0, known_peers.size() - 1)];
            r.ip = peer[47:16];
            // mostly a heartbeat, sometimes same address on another port
            if ($urandom_range(0, 7) != 0)
               r.port = peer[15:0];
            else
               known_peers.push_back({r.ip, r.port});
         end else begin
            known_peers.push_back({r.ip, r.port});
         end
         if (known_peers.size() > 64)
            void'(known_peers.pop_front());
      end else if (pick < 75) begin
         r.opcode = OP_SWEEP;
      end else if (pick < 93) begin
         r.opcode = OP_LIST;
      end else begin
         r.opcode = OP_UNUSED;
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t error: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic offer_request(input peer_req_type r);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_peer_ip <= r.ip;
      req_peer_port <= r.port;
      req_current_time <= r.now;
      do @(posedge clock); while (!req_ready);
      predict_results(r);
   endtask

   task automatic wait_for_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_rsps.size() != 0) begin
         $display("peer_registry_with_aging: mismatch");
         $finish;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      timeout_model = value;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            flag_mismatch("result with none expected, status", rsp_status, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status != want.status)
               flag_mismatch("status", rsp_status, want.status);
            if (rsp_slot != want.slot)
               flag_mismatch("slot", rsp_slot, want.slot);
            if (rsp_entry_ip != want.ip)
               flag_mismatch("entry_ip", rsp_entry_ip, want.ip);
            if (rsp_entry_port != want.port)
               flag_mismatch("entry_port", rsp_entry_port, want.port);
            if (rsp_expired_count != want.count)
               flag_mismatch("expired_count", rsp_expired_count, want.count);
            if (rsp_last != want.last)
               flag_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // result side ready, with stall bursts and one long hold-off
   initial begin
      int span;
      forever begin
         span = $urandom_range(1, 16);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (stall_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin
      peer_req_type row;
      int p;
      int counted;
      bit hold_done;
      logic [TIMEOUT_W-1:0] phase_timeout [NUM_PHASES];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_REGISTER;
      req_peer_ip <= '0;
      req_peer_port <= '0;
      req_current_time <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= TIMEOUT_RESET;
      hold_done = 1'b0;
      foreach (registry_valid[i]) begin
         registry_valid[i] = 1'b0;
         registry_ip[i] = '0;
         registry_port[i] = '0;
         registry_seen[i] = '0;
      end
      timeout_model = TIMEOUT_RESET;
      phase_timeout[0] = TIMEOUT_RESET;
      phase_timeout[1] = 16'd1;
      phase_timeout[2] = 16'd0;
      phase_timeout[3] = 16'hFFFF;
      phase_timeout[4] = TIMEOUT_W'($urandom_range(2, 65534));

      // directed table, timeout at its reset value
      add_row(OP_LIST, '0, '0, '0, 1'b1, mk_rsp(STAT_END, 0, '0, '0, 0, 1'b1));
      add_row(OP_SWEEP, '1, '1, '1, 1'b1, mk_rsp(STAT_SWEPT, 0, '0, '0, 0, 1'b1));
      add_row(OP_UNUSED, '1, '1, '1, 1'b0, '0);
      add_row(OP_REGISTER, '0, '0, '0, 1'b1, mk_rsp(STAT_ADDED, 0, '0, '0, 0, 1'b1));
      add_row(OP_REGISTER, '1, '1, '1, 1'b1, mk_rsp(STAT_ADDED, 1, '1, '1, 0, 1'b1));
      add_row(OP_REGISTER, '0, '1, 32'd5, 1'b1, mk_rsp(STAT_ADDED, 2, '0, '1, 0, 1'b1));
      add_row(OP_REGISTER, '1, '0, 32'd6, 1'b1, mk_rsp(STAT_ADDED, 3, '1, '0, 0, 1'b1));
      add_row(OP_REGISTER, '0, '0, 32'd10, 1'b1,
              mk_rsp(STAT_REFRESHED, 0, '0, '0, 0, 1'b1));
      add_row(OP_REGISTER, '1, '1, 32'd20, 1'b1,
              mk_rsp(STAT_REFRESHED, 1, '1, '1, 0, 1'b1));
      add_row(OP_LIST, 32'h1234_5678, 16'h9abc, 32'd21, 1'b0, '0);
      add_row(OP_SWEEP, '0, '0, 32'd59, 1'b0, '0);
      add_row(OP_SWEEP, '0, '0, 32'd66, 1'b0, '0);
      add_row(OP_REGISTER, 32'hc0a8_0001, 16'd10666, 32'd66, 1'b0, '0);
      add_row(OP_LIST, '0, '0, '0, 1'b0, '0);
      add_row(OP_UNUSED, '0, '0, '0, 1'b0, '0);
      add_row(OP_SWEEP, '0, '0, '1, 1'b0, '0);
      add_row(OP_LIST, '1, '1, '1, 1'b1, mk_rsp(STAT_END, 0, '0, '0, 0, 1'b1));
      add_row(OP_REGISTER, 32'h8000_0000, 16'h8000, 32'h8000_0000, 1'b1,
              mk_rsp(STAT_ADDED, 0, 32'h8000_0000, 16'h8000, 0, 1'b1));
      add_row(OP_REGISTER, 32'h7fff_ffff, 16'h7fff, 32'h7fff_ffff, 1'b1,
              mk_rsp(STAT_ADDED, 1, 32'h7fff_ffff, 16'h7fff, 0, 1'b1));
      add_row(OP_SWEEP, '0, '0, 32'h8000_003b, 1'b0, '0);
      add_row(OP_LIST, '0, '0, '0, 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         offer_request(directed_rows[i]);
      wait_for_idle();

      for (p = 0; p < NUM_PHASES; p++) begin
         if (p != 0)
            write_timeout(phase_timeout[p]);
         // time counter crosses its wrap in this phase
         if (p == 3)
            now_s = 32'hFFFF_FF00;
         idle_on = (p != NUM_PHASES - 1);
         stall_on = idle_on;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            row = random_request();
            if (row.opcode != OP_UNUSED)
               counted++;
            if (p == 1 && counted == 20 && !hold_done) begin
               long_hold = 1'b1;
               hold_done = 1'b1;
            end
            offer_request(row);
         end
         wait_for_idle();
      end

      if (mismatch_count == 0)
         $display("peer_registry_with_aging: match");
      else
         $display("peer_registry_with_aging: mismatch");
      $finish;
   end

endmodule

// ===== peer_registry_with_aging.f =====
rtl/core/prwa_pkg.sv
rtl/core/prwa_ram.sv
rtl/core/prwa_engine.sv
rtl/core/peer_registry_with_aging.sv
verif/tb_top.sv
